// ===== rtl/sacl_pkg.sv =====
// Shared types, geometry constants and helpers for the set-associative cache core.
// No dependencies; every other RTL file imports this package.
`default_nettype none

package sacl_pkg;

	localparam int WAYS       = 2;
	localparam int SETS       = 512;
	localparam int LINE_BYTES = 64;
	localparam int ADDR_BITS  = 48;

	localparam int OFF_W  = $clog2(LINE_BYTES);
	localparam int IDX_W  = $clog2(SETS);
	localparam int TAG_W  = ADDR_BITS - OFF_W - IDX_W;
	localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int AGE_W  = WAY_W;
	localparam int CNT_W  = 32;
	localparam int VTAG_W = 33;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [TAG_W-1:0] tag_t;
	typedef logic [WAY_W-1:0] way_t;
	typedef logic [AGE_W-1:0] age_t;
	typedef logic [CNT_W-1:0] cnt_t;

	localparam age_t AGE_OLDEST = age_t'(WAYS - 1);
	localparam cnt_t CNT_MAX    = '1;

	// One memory row holds the complete state of a set.
	typedef struct packed {
		logic [WAYS-1:0]       valid;
		age_t [WAYS-1:0]       age;
		tag_t [WAYS-1:0]       tag;
	} row_t;

	// Outcome of one lookup against a set.
	typedef struct packed {
		logic hit;
		way_t way;
		logic victim_valid;
		tag_t victim_tag;
	} look_t;

	// State of a set after reset: nothing valid, each way's age is its way number.
	function automatic row_t init_row();
		row_t r;
		r = '0;
		for (int w = 0; w < WAYS; w++) begin
			r.age[w] = age_t'(w);
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/set_assoc_cache_lru_core.sv =====
// Set-associative tag cache with true LRU, one request per cycle while the result output is not stalled.
// A request is accepted into the stage register while its set row is read; its result is
// registered when that stage advances, which waits while res_valid is high and res_ready low.
// Each set row is read, updated and written back once, and a request to the set just
// updated takes the written row by forwarding. Reset: counters clear at once; a clearing
// sweep then writes every set row in turn, during which addr_ready stays low.
`default_nettype none

module set_assoc_cache_lru_core
	import sacl_pkg::*;
(
	input  wire                clk,
	input  wire                arst_n,
	input  wire                addr_valid,
	output logic               addr_ready,
	input  wire [ADDR_BITS-1:0] address,
	output logic               res_valid,
	input  wire                res_ready,
	output logic               hit,
	output logic               way,
	output logic               victim_valid,
	output logic [VTAG_W-1:0]  victim_tag,
	output logic [CNT_W-1:0]   hit_count,
	output logic [CNT_W-1:0]   miss_count
);

	logic  init_done;
	logic  acc;
	logic  adv_s1;
	idx_t  in_idx;
	tag_t  in_tag;

	logic  valid_s1;
	idx_t  idx_s1;
	tag_t  tag_s1;
	logic  fwd_s1;
	row_t  fwd_row_s1;

	row_t  rd_row;
	row_t  cur_row;
	row_t  upd_row;
	look_t look;

	cnt_t  hits_q;
	cnt_t  misses_q;
	cnt_t  hits_nxt;
	cnt_t  misses_nxt;

	assign in_idx = address[OFF_W +: IDX_W];
	assign in_tag = address[OFF_W + IDX_W +: TAG_W];

	assign adv_s1     = valid_s1 && (!res_valid || res_ready);
	assign addr_ready = init_done && (!valid_s1 || adv_s1);
	assign acc        = addr_valid && addr_ready;

	sacl_set_ram u_ram (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_en     (acc),
		.rd_idx    (in_idx),
		.rd_row    (rd_row),
		.wr_en     (adv_s1),
		.wr_idx    (idx_s1),
		.wr_row    (upd_row),
		.init_done (init_done)
	);

	// The read issued alongside a write to the same set sees the old row, so take the new one.
	assign cur_row = fwd_s1 ? fwd_row_s1 : rd_row;

	sacl_lookup u_lookup (
		.row     (cur_row),
		.tag     (tag_s1),
		.look    (look),
		.new_row (upd_row)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			fwd_s1   <= 1'b0;
		end else if (acc) begin
			valid_s1 <= 1'b1;
			fwd_s1   <= adv_s1 && (idx_s1 == in_idx);
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
			fwd_s1   <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			idx_s1     <= in_idx;
			tag_s1     <= in_tag;
			fwd_row_s1 <= upd_row;
		end
	end

	always_comb begin
		hits_nxt   = hits_q;
		misses_nxt = misses_q;
		if (look.hit) begin
			if (hits_q != CNT_MAX) begin
				hits_nxt = hits_q + 1'b1;
			end
		end else if (misses_q != CNT_MAX) begin
			misses_nxt = misses_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hits_q    <= '0;
			misses_q  <= '0;
			res_valid <= 1'b0;
		end else begin
			if (adv_s1) begin
				hits_q    <= hits_nxt;
				misses_q  <= misses_nxt;
				res_valid <= 1'b1;
			end else if (res_ready) begin
				res_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			hit          <= look.hit;
			way          <= look.way[0];
			victim_valid <= look.victim_valid;
			victim_tag   <= VTAG_W'(look.victim_tag);
			hit_count    <= hits_nxt;
			miss_count   <= misses_nxt;
		end
	end

`ifndef ASSERT_OFF
	a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		!init_done |-> !addr_ready)
		else $error("request accepted during the clearing sweep");

	a_adv_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 |=> res_valid)
		else $error("processed request produced no result");

	a_hit_no_victim: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && hit |-> !victim_valid && victim_tag == '0)
		else $error("hit result carries a victim");

	a_counts_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> hits_q >= $past(hits_q) && misses_q >= $past(misses_q))
		else $error("hit or miss total decreased");

	a_one_count_per_request: assert property (@(posedge clk) disable iff (!arst_n)
		!adv_s1 |=> $stable(hits_q) && $stable(misses_q))
		else $error("totals changed without a request");
`endif

endmodule

`default_nettype wire

// ===== rtl/sacl_set_ram.sv =====
// Set memory: one row per set with tags, valid bits and LRU ages.
// Synchronous, registered read; a clearing sweep runs after reset.
// Depends on sacl_pkg.
`default_nettype none

module sacl_set_ram
	import sacl_pkg::*;
(
	input  wire  clk,
	input  wire  arst_n,
	input  wire  rd_en,
	input  idx_t rd_idx,
	output row_t rd_row,
	input  wire  wr_en,
	input  idx_t wr_idx,
	input  row_t wr_row,
	output logic init_done
);

	row_t mem [SETS];

	idx_t clr_idx_q;
	logic clr_busy_q;

	logic wen;
	idx_t widx;
	row_t wdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q  <= '0;
			clr_busy_q <= 1'b1;
		end else if (clr_busy_q) begin
			clr_idx_q <= clr_idx_q + 1'b1;
			if (clr_idx_q == idx_t'(SETS - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// The sweep owns the write port until every row holds its reset state.
	always_comb begin
		if (clr_busy_q) begin
			wen   = 1'b1;
			widx  = clr_idx_q;
			wdata = init_row();
		end else begin
			wen   = wr_en;
			widx  = wr_idx;
			wdata = wr_row;
		end
	end

	always_ff @(posedge clk) begin
		if (wen) begin
			mem[widx] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_row <= mem[rd_idx];
		end
	end

	assign init_done = !clr_busy_q;

endmodule

`default_nettype wire

// ===== rtl/sacl_lookup.sv =====
// Tag compare, victim choice and LRU age update for one set row.
// Purely combinational; depends on sacl_pkg.
`default_nettype none

module sacl_lookup
	import sacl_pkg::*;
(
	input  row_t  row,
	input  tag_t  tag,
	output look_t look,
	output row_t  new_row
);

	logic found;
	way_t hit_way;
	way_t vict_way;
	way_t chosen;
	age_t old_age;

	always_comb begin
		found    = 1'b0;
		hit_way  = '0;
		vict_way = '0;
		// Walking downward lets the lowest matching way win.
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (row.valid[w] && row.tag[w] == tag) begin
				found   = 1'b1;
				hit_way = way_t'(w);
			end
			if (row.age[w] == AGE_OLDEST) begin
				vict_way = way_t'(w);
			end
		end

		chosen  = found ? hit_way : vict_way;
		old_age = row.age[chosen];

		new_row = row;
		for (int k = 0; k < WAYS; k++) begin
			if (row.age[k] < old_age) begin
				new_row.age[k] = row.age[k] + 1'b1;
			end
		end
		new_row.age[chosen] = '0;
		if (!found) begin
			new_row.tag[chosen]   = tag;
			new_row.valid[chosen] = 1'b1;
		end

		look.hit          = found;
		look.way          = chosen;
		look.victim_valid = !found && row.valid[chosen];
		look.victim_tag   = (!found && row.valid[chosen]) ? row.tag[chosen] : '0;
	end

endmodule

`default_nettype wire
